/* rtl/core/wbst_pkg.sv */
// Shared constants, codes and controller/datapath struct types for the white blob tracker.
package wbst_pkg;

   localparam int PIX_W     = 8;
   localparam int COL_W     = 13;
   localparam int HGT_W     = 12;
   localparam int ROW_W     = 12;
   localparam int OUT_ROW_W = 11;
   localparam int DRIVE_W   = 16;
   localparam int Q_W       = 15;
   localparam int DIV_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   localparam int DEF_MAX_ROW_BYTES = 6144;
   localparam int DEF_MAX_ROWS      = 2048;

   localparam logic [COL_W-1:0] RESET_ROW_BYTES    = 13'd1920;
   localparam logic [HGT_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_BYTES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'hFF;
   localparam logic [COL_W:0]   PIXEL_STEP  = 14'd3;

   localparam logic [15:0] RECIP3       = 16'd43691;
   localparam int          RECIP3_SHIFT = 17;

   localparam logic [DRIVE_W-1:0] DRIVE_ZERO = 16'h0000;
   localparam logic [DRIVE_W-1:0] FWD_FULL   = 16'h8000;
   localparam logic [DRIVE_W-1:0] TURN_POS   = 16'h7FFF;
   localparam logic [DRIVE_W-1:0] TURN_NEG   = 16'h8000;

   typedef struct packed {
      logic accept;
      logic snap;
      logic calc_third;
      logic decide;
      logic div_step;
      logic load;
   } wbst_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic need_div;
      logic out_free;
   } wbst_status_type;

endpackage

/* rtl/core/wbst_ifs.sv */
// Handshake channel interfaces for pixels, results and register writes.
interface wbst_req_if;
   import wbst_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface wbst_rsp_if;
   import wbst_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        target_found;
   logic [DRIVE_W-1:0]          forward_speed;
   logic signed [DRIVE_W-1:0]   turn_rate;
   logic [COL_W-1:0]            target_column;
   logic [OUT_ROW_W-1:0]        target_row;
   modport source (output valid, target_found, forward_speed, turn_rate, target_column,
                   target_row, input ready);
   modport sink (input valid, target_found, forward_speed, turn_rate, target_column,
                 target_row, output ready);
endinterface

interface wbst_csr_if;
   import wbst_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/wbst_datapath.sv */
// Datapath: raster counters, white tracking, steering decision, divider and result register.
module wbst_datapath #(
   parameter int MAX_ROW_BYTES = wbst_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_ROWS      = wbst_pkg::DEF_MAX_ROWS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wbst_pkg::wbst_cmd_type                  cmd,
   output wbst_pkg::wbst_status_type               status,
   input  logic [wbst_pkg::PIX_W-1:0]              red,
   input  logic [wbst_pkg::PIX_W-1:0]              green,
   input  logic [wbst_pkg::PIX_W-1:0]              blue,
   input  logic                                    csr_we,
   input  logic [wbst_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [wbst_pkg::CSR_DAT_W-1:0]          csr_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_target_found,
   output logic [wbst_pkg::DRIVE_W-1:0]            rsp_forward_speed,
   output logic signed [wbst_pkg::DRIVE_W-1:0]     rsp_turn_rate,
   output logic [wbst_pkg::COL_W-1:0]              rsp_target_column,
   output logic [wbst_pkg::OUT_ROW_W-1:0]          rsp_target_row
);
   import wbst_pkg::*;

   localparam int RB_FULL = (1 << COL_W) - 1;
   localparam int H_FULL  = (1 << HGT_W) - 1;
   localparam int RB_CAP  = (MAX_ROW_BYTES > RB_FULL) ? RB_FULL : MAX_ROW_BYTES;
   localparam int H_CAP   = (MAX_ROWS > H_FULL) ? H_FULL : MAX_ROWS;

   logic [COL_W-1:0] row_bytes_ff;
   logic [HGT_W-1:0] frame_height_ff;
   logic [COL_W-1:0] rb_eff;
   logic [HGT_W-1:0] h_eff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             first_seen_ff, first_seen_in;
   logic [COL_W-1:0] first_col_ff, first_col_in;
   logic [ROW_W-1:0] first_row_ff, first_row_in;
   logic             later_seen_ff, later_seen_in;
   logic [COL_W-1:0] later_col_ff, later_col_in;
   logic [ROW_W-1:0] later_row_ff, later_row_in;

   logic             white, row_end, frame_end;
   logic [COL_W:0]   col_sum;
   logic [ROW_W:0]   row_sum;
   logic [COL_W-1:0] mid_col_in;
   logic [ROW_W-1:0] mid_row_in;

   logic             found_ff;
   logic [COL_W-1:0] mid_col_ff;
   logic [ROW_W-1:0] mid_row_ff;
   logic [DIV_W-1:0] third_ff;
   logic [COL_W+15:0] third_prod;

   logic [DIV_W-1:0]        half;
   logic                    turn_sel, big, fwd_ok, need_div;
   logic signed [COL_W:0]   diff;
   logic [COL_W:0]          diff_neg;
   logic [COL_W-1:0]        abs_diff;
   logic [DIV_W-1:0]        num_in, den_in;
   logic [DRIVE_W-1:0]      fwd_pre, turn_pre;

   logic [DRIVE_W-1:0] fwd_ff, turn_ff;
   logic               div_use_ff, div_turn_ff, div_neg_ff;
   logic [DIV_W-1:0]   rem_ff, den_ff;
   logic [Q_W-1:0]     quo_ff;
   logic [DIV_W:0]     rem_shift;
   logic               rem_ge;

   logic                 out_valid_ff;
   logic                 out_found_ff;
   logic [DRIVE_W-1:0]   out_fwd_ff, out_fwd_in;
   logic [DRIVE_W-1:0]   out_turn_ff, out_turn_in;
   logic [COL_W-1:0]     out_col_ff;
   logic [OUT_ROW_W-1:0] out_row_ff;

   assign rb_eff = (row_bytes_ff > COL_W'(RB_CAP)) ? COL_W'(RB_CAP) : row_bytes_ff;
   assign h_eff  = (frame_height_ff > HGT_W'(H_CAP)) ? HGT_W'(H_CAP) : frame_height_ff;

   assign white     = (red == WHITE_LEVEL) && (green == WHITE_LEVEL) && (blue == WHITE_LEVEL);
   assign row_end   = ({1'b0, col_ff} + PIXEL_STEP) >= {1'b0, rb_eff};
   assign frame_end = row_end && (({1'b0, row_ff} + (ROW_W + 1)'(1)) >= {1'b0, h_eff});

   always_comb begin
      first_seen_in = first_seen_ff;
      first_col_in  = first_col_ff;
      first_row_in  = first_row_ff;
      later_seen_in = later_seen_ff;
      later_col_in  = later_col_ff;
      later_row_in  = later_row_ff;
      if (white) begin
         if (!first_seen_ff) begin
            first_seen_in = 1'b1;
            first_col_in  = col_ff;
            first_row_in  = row_ff;
         end else begin
            later_seen_in = 1'b1;
            later_col_in  = col_ff;
            later_row_in  = row_ff;
         end
      end
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + PIXEL_STEP[COL_W-1:0];
         row_in = row_ff;
      end
   end

   assign col_sum    = {1'b0, first_col_in} + {1'b0, later_col_in};
   assign row_sum    = {1'b0, first_row_in} + {1'b0, later_row_in};
   assign mid_col_in = later_seen_in ? col_sum[COL_W:1] : first_col_in;
   assign mid_row_in = later_seen_in ? row_sum[ROW_W:1] : first_row_in;

   assign third_prod = rb_eff * RECIP3;

   // Steering decision on the captured midpoint.
   assign half     = rb_eff[COL_W-1:1];
   assign turn_sel = (mid_col_ff < {1'b0, third_ff}) ||
                     (mid_col_ff > (rb_eff - {1'b0, third_ff}));
   assign diff     = $signed({2'b00, half}) - $signed({1'b0, mid_col_ff});
   assign diff_neg = -diff;
   assign abs_diff = diff[COL_W] ? diff_neg[COL_W-1:0] : diff[COL_W-1:0];
   assign big      = abs_diff >= {1'b0, half};
   assign fwd_ok   = (h_eff != '0) && (mid_row_ff < h_eff);

   always_comb begin
      fwd_pre  = DRIVE_ZERO;
      turn_pre = DRIVE_ZERO;
      need_div = 1'b0;
      num_in   = h_eff - mid_row_ff;
      den_in   = h_eff;
      if (found_ff) begin
         if (turn_sel) begin
            num_in = abs_diff[DIV_W-1:0];
            den_in = half;
            if (half != '0) begin
               if (big) begin
                  turn_pre = diff[COL_W] ? TURN_NEG : TURN_POS;
               end else begin
                  need_div = 1'b1;
               end
            end
         end else if (fwd_ok) begin
            if (mid_row_ff == '0) begin
               fwd_pre = FWD_FULL;
            end else begin
               need_div = 1'b1;
            end
         end
      end
   end

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};

   always_comb begin
      out_fwd_in  = fwd_ff;
      out_turn_in = turn_ff;
      if (div_use_ff) begin
         if (div_turn_ff) begin
            out_turn_in = div_neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
         end else begin
            out_fwd_in = {1'b0, quo_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff    <= RESET_ROW_BYTES;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         col_ff          <= '0;
         row_ff          <= '0;
         first_seen_ff   <= 1'b0;
         later_seen_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ROW_BYTES:    row_bytes_ff    <= csr_data[COL_W-1:0];
               REG_FRAME_HEIGHT: frame_height_ff <= csr_data[HGT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            col_ff        <= col_in;
            row_ff        <= row_in;
            first_seen_ff <= frame_end ? 1'b0 : first_seen_in;
            later_seen_ff <= frame_end ? 1'b0 : later_seen_in;
         end
         if (cmd.load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         first_col_ff <= first_col_in;
         first_row_ff <= first_row_in;
         later_col_ff <= later_col_in;
         later_row_ff <= later_row_in;
      end
      if (cmd.snap) begin
         found_ff   <= first_seen_in;
         mid_col_ff <= mid_col_in;
         mid_row_ff <= mid_row_in;
      end
      if (cmd.calc_third) begin
         third_ff <= third_prod[RECIP3_SHIFT +: DIV_W];
      end
      if (cmd.decide) begin
         fwd_ff      <= fwd_pre;
         turn_ff     <= turn_pre;
         div_use_ff  <= need_div;
         div_turn_ff <= turn_sel;
         div_neg_ff  <= diff[COL_W];
         rem_ff      <= num_in;
         den_ff      <= den_in;
         quo_ff      <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? DIV_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DIV_W-1:0];
         quo_ff <= {quo_ff[Q_W-2:0], rem_ge};
      end
      if (cmd.load) begin
         out_found_ff <= found_ff;
         out_fwd_ff   <= out_fwd_in;
         out_turn_ff  <= out_turn_in;
         out_col_ff   <= found_ff ? mid_col_ff : '0;
         out_row_ff   <= found_ff ? mid_row_ff[OUT_ROW_W-1:0] : '0;
      end
   end

   assign status.frame_end = frame_end;
   assign status.need_div  = need_div;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_target_found  = out_found_ff;
   assign rsp_forward_speed = out_fwd_ff;
   assign rsp_turn_rate     = out_turn_ff;
   assign rsp_target_column = out_col_ff;
   assign rsp_target_row    = out_row_ff;

endmodule

/* rtl/core/wbst_ctrl.sv */
// Controller state machine that sequences pixel intake and the end-of-frame calculation.
module wbst_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  wbst_pkg::wbst_status_type  status,
   output wbst_pkg::wbst_cmd_type     cmd
);
   import wbst_pkg::*;

   localparam int CNT_W = $clog2(Q_W);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_THIRD  = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd            = '0;
      cmd.accept     = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.frame_end) begin
               cmd.snap = 1'b1;
               state_in = ST_THIRD;
            end
         end
         ST_THIRD: begin
            cmd.calc_third = 1'b1;
            state_in       = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cnt_in     = '0;
            state_in   = status.need_div ? ST_DIV : ST_LOAD;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/core/white_blob_steering_tracker.sv */
// Top level of the white blob steering tracker: controller, datapath and channel wiring.
//
//   Channel  Direction  Carries
//   req      in         one RGB pixel per item, raster order
//   rsp      out        one steering result per frame
//   csr      in         register writes: 0 = row_bytes, 1 = frame_height
//
// A pixel is taken every cycle while no frame-end calculation is running.
// After the last pixel of a frame the input stalls through the THIRD, DECIDE and LOAD
// states, plus DIV when a drive value needs the shared one-bit-per-cycle divider.
// The result register holds one item; pixels of the next frame flow while it waits, but
// the next frame end stalls further until that register has been taken.
// Synchronous reset restores row_bytes 1920 and frame_height 480 and clears all counters.
module white_blob_steering_tracker #(
   parameter int MAX_ROW_BYTES = wbst_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_ROWS      = wbst_pkg::DEF_MAX_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   wbst_req_if.sink          req_chan,
   wbst_rsp_if.source        rsp_chan,
   wbst_csr_if.sink          csr_chan
);
   import wbst_pkg::*;

   wbst_cmd_type    cmd;
   wbst_status_type status;

   assign csr_chan.ready = 1'b1;

   wbst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wbst_datapath #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_ROWS      (MAX_ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .red               (req_chan.red),
      .green             (req_chan.green),
      .blue              (req_chan.blue),
      .csr_we            (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_target_found  (rsp_chan.target_found),
      .rsp_forward_speed (rsp_chan.forward_speed),
      .rsp_turn_rate     (rsp_chan.turn_rate),
      .rsp_target_column (rsp_chan.target_column),
      .rsp_target_row    (rsp_chan.target_row)
   );

endmodule

/* tb/sv/tb_white_blob_steering_tracker.sv */
// Self-checking testbench for the white blob steering tracker: pixel streams against a predictor.
module tb_white_blob_steering_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import wbst_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 1400;
   localparam int MAX_REPORTS   = 40;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_t;

   typedef struct packed {
      logic                      found;
      logic [DRIVE_W-1:0]        fwd;
      logic signed [DRIVE_W-1:0] turn;
      logic [COL_W-1:0]          col;
      logic [OUT_ROW_W-1:0]      row;
   } steer_t;

   typedef struct {
      bit                   is_reg;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] value;
      pixel_t               pix;
      bit                   typed;
      steer_t               want;
   } plan_row_t;

   localparam steer_t NO_TARGET = '0;

   logic clock;
   logic reset;

   wbst_req_if req_bus ();
   wbst_rsp_if rsp_bus ();
   wbst_csr_if csr_bus ();

   white_blob_steering_tracker u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state.
   int unsigned cfg_row_bytes = 1920;
   int unsigned cfg_height    = 480;
   int unsigned col_cnt       = 0;
   int unsigned row_cnt       = 0;
   bit          first_hit     = 0;
   int unsigned first_col     = 0;
   int unsigned first_row     = 0;
   bit          later_hit     = 0;
   int unsigned later_col     = 0;
   int unsigned later_row     = 0;

   steer_t    pending_steer[$];
   plan_row_t plan[$];

   int  mismatches      = 0;
   int  pixels_sent     = 0;
   int  reg_writes      = 0;
   int  frames_expected = 0;
   int  results_checked = 0;
   int  found_count     = 0;
   int  turn_count      = 0;
   int  forward_count   = 0;
   int  quiet_cycles    = 0;
   int  burst_left      = 0;
   bit  steady          = 0;
   int  sink_cycle      = 0;
   int  sink_mode       = 1;
   int  stall_left      = 0;
   steer_t oldest;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t ns %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   function automatic steer_t steer_from_blob();
      int unsigned rb, h, mx, my, half, third;
      longint      d, mag;
      steer_t      s;
      s = NO_TARGET;
      rb = (cfg_row_bytes > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : cfg_row_bytes;
      h = (cfg_height > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cfg_height;
      if (!first_hit) return s;
      mx = first_col;
      my = first_row;
      if (later_hit) begin
         mx = (first_col + later_col) >> 1;
         my = (first_row + later_row) >> 1;
      end
      half = rb / 2;
      third = rb / 3;
      if (mx < third || mx > rb - third) begin
         if (half != 0) begin
            d = longint'(half) - longint'(mx);
            mag = ((d < 0) ? -d : d) << 15;
            mag = mag / longint'(half);
            if (d >= 0) s.turn = (mag > 32767) ? TURN_POS : DRIVE_W'(mag);
            else s.turn = (mag > 32768) ? TURN_NEG : DRIVE_W'(-mag);
         end
      end else if (h != 0 && my < h) begin
         s.fwd = DRIVE_W'((longint'(h - my) << 15) / longint'(h));
      end
      s.found = 1'b1;
      s.col = COL_W'(mx);
      s.row = OUT_ROW_W'(my);
      return s;
   endfunction

   function automatic void track_pixel(input pixel_t p, output bit ended, output steer_t result);
      int unsigned rb, h;
      bit          white, row_end;
      rb = (cfg_row_bytes > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : cfg_row_bytes;
      h = (cfg_height > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cfg_height;
      white = (p.red == WHITE_LEVEL) && (p.green == WHITE_LEVEL) && (p.blue == WHITE_LEVEL);
      row_end = (col_cnt + 3 >= rb);
      ended = row_end && (row_cnt + 1 >= h);
      result = NO_TARGET;
      if (white) begin
         if (!first_hit) begin
            first_hit = 1;
            first_col = col_cnt;
            first_row = row_cnt;
         end else begin
            later_hit = 1;
            later_col = col_cnt;
            later_row = row_cnt;
         end
      end
      if (row_end) begin
         col_cnt = 0;
         row_cnt = ended ? 0 : row_cnt + 1;
      end else begin
         col_cnt = col_cnt + 3;
      end
      if (ended) begin
         result = steer_from_blob();
         first_hit = 0;
         first_col = 0;
         first_row = 0;
         later_hit = 0;
         later_col = 0;
         later_row = 0;
      end
   endfunction

   function automatic void add_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DAT_W-1:0] value);
      plan_row_t r;
      r = '{is_reg: 1, idx: idx, value: value, pix: '0, typed: 0, want: NO_TARGET};
      plan.push_back(r);
   endfunction

   function automatic void add_pix(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                                   input logic [PIX_W-1:0] blue, input bit typed,
                                   input steer_t want);
      plan_row_t r;
      r = '{is_reg: 0, idx: '0, value: '0, pix: {red, green, blue}, typed: typed, want: want};
      plan.push_back(r);
   endfunction

   function automatic pixel_t random_pixel(input int density);
      pixel_t p;
      p.red = PIX_W'($urandom);
      p.green = PIX_W'($urandom);
      p.blue = PIX_W'($urandom);
      if (density != 0 && $urandom_range(0, density - 1) == 0) begin
         p = {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
      end else begin
         case ($urandom_range(0, 3))
            2: begin
               p = {WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
               case ($urandom_range(0, 2))
                  0: p.red = PIX_W'($urandom_range(0, 254));
                  1: p.green = PIX_W'($urandom_range(0, 254));
                  default: p.blue = PIX_W'($urandom_range(0, 254));
               endcase
            end
            3: begin
               p.red = $urandom_range(0, 1) ? WHITE_LEVEL : '0;
               p.green = $urandom_range(0, 1) ? WHITE_LEVEL : '0;
               p.blue = $urandom_range(0, 1) ? WHITE_LEVEL : '0;
            end
            default: ;
         endcase
      end
      return p;
   endfunction

   function automatic int pick_density();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 2;
         2: return 5;
         3: return 12;
         4: return 40;
         default: return 300;
      endcase
   endfunction

   function automatic int unsigned pick_row_bytes();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return $urandom_range(1, 2);
         7: return $urandom_range(3, 40);
         8: return $urandom_range(100, 700);
         9: return DEF_MAX_ROW_BYTES;
         10: return $urandom_range(DEF_MAX_ROW_BYTES + 1, 8191);
         11: return 3 * $urandom_range(11, 30);
         default: return 3 * $urandom_range(1, 10);
      endcase
   endfunction

   function automatic int unsigned pick_height();
      case ($urandom_range(0, 9))
         0: return 0;
         7: return $urandom_range(7, 30);
         8: return $urandom_range(DEF_MAX_ROWS + 1, 4095);
         9: return DEF_MAX_ROWS;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   // All tasks below are entered and left at a falling clock edge.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_steer.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == REG_ROW_BYTES) cfg_row_bytes = 32'(value);
      else if (idx == REG_FRAME_HEIGHT) cfg_height = 32'(value[HGT_W-1:0]);
      reg_writes++;
      @(negedge clock);
   endtask

   task automatic send_pixel(input pixel_t p, input bit typed, input steer_t want);
      int     gap;
      bit     ended;
      steer_t result;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(7, 25)
                                                         : $urandom_range(0, 6));
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.red <= p.red;
      req_bus.green <= p.green;
      req_bus.blue <= p.blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_pixel(p, ended, result);
      if (ended) begin
         pending_steer.push_back(typed ? want : result);
         frames_expected++;
      end
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic run_phase(input bit set_rb, input int unsigned rb, input bit set_h,
                            input int unsigned h, input int count, input int density);
      wait_idle();
      if (set_rb) write_reg(REG_ROW_BYTES, CSR_DAT_W'(rb));
      if (set_h) write_reg(REG_FRAME_HEIGHT, CSR_DAT_W'(h));
      if ($urandom_range(0, 7) == 0) begin
         write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CSR_DAT_W'($urandom));
      end
      csr_bus.valid <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);
      repeat (count) send_pixel(random_pixel(density), 0, NO_TARGET);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         sink_cycle++;
         if (sink_cycle % 300 == 0) sink_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            case (sink_mode)
               0: rsp_bus.ready <= 1'b1;
               1: begin
                  if ($urandom_range(0, 3) == 0) begin
                     stall_left = $urandom_range(0, 3);
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                  end
               end
               default: begin
                  if ($urandom_range(0, 7) == 0) begin
                     stall_left = $urandom_range(5, 30);
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_steer.size() == 0) begin
            report_mismatch("result with nothing expected, target_column",
                            int'(rsp_bus.target_column), 0);
         end else begin
            oldest = pending_steer.pop_front();
            results_checked++;
            if (oldest.found) found_count++;
            if (oldest.turn != 0) turn_count++;
            if (oldest.fwd != 0) forward_count++;
            if (rsp_bus.target_found !== oldest.found)
               report_mismatch("target_found", int'(rsp_bus.target_found), int'(oldest.found));
            if (rsp_bus.forward_speed !== oldest.fwd)
               report_mismatch("forward_speed", int'(rsp_bus.forward_speed), int'(oldest.fwd));
            if (rsp_bus.turn_rate !== oldest.turn)
               report_mismatch("turn_rate", int'($signed(rsp_bus.turn_rate)),
                               int'($signed(oldest.turn)));
            if (rsp_bus.target_column !== oldest.col)
               report_mismatch("target_column", int'(rsp_bus.target_column), int'(oldest.col));
            if (rsp_bus.target_row !== oldest.row)
               report_mismatch("target_row", int'(rsp_bus.target_row), int'(oldest.row));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("No item moved for %0d cycles; %0d results still awaited.",
                  quiet_cycles, pending_steer.size());
         $display("white_blob_steering_tracker: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int  i;
      int  loop_pixels;
      bit  reg_busy;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      reg_busy = 0;

      // Single-pixel frames: saturated turn, then black, then channels one short of white.
      add_reg(REG_ROW_BYTES, 13'd3);
      add_reg(REG_FRAME_HEIGHT, 13'd1);
      add_pix(8'hFF, 8'hFF, 8'hFF, 1, steer_t'{1'b1, DRIVE_ZERO, TURN_POS, 13'd0, 11'd0});
      add_pix(8'h00, 8'h00, 8'h00, 1, NO_TARGET);
      add_pix(8'hFF, 8'hFF, 8'hFE, 1, NO_TARGET);
      add_pix(8'hFE, 8'hFF, 8'hFF, 1, NO_TARGET);
      add_pix(8'hFF, 8'hFE, 8'hFF, 1, NO_TARGET);
      // Three by two frames: full forward speed, then a two-point midpoint.
      add_reg(REG_ROW_BYTES, 13'd9);
      add_reg(REG_FRAME_HEIGHT, 13'd2);
      add_pix(8'h00, 8'h00, 8'h00, 0, NO_TARGET);
      add_pix(8'hFF, 8'hFF, 8'hFF, 0, NO_TARGET);
      for (i = 0; i < 3; i++) add_pix(8'h12, 8'h34, 8'h56, 0, NO_TARGET);
      add_pix(8'h00, 8'h00, 8'h00, 1, steer_t'{1'b1, FWD_FULL, DRIVE_ZERO, 13'd3, 11'd0});
      add_pix(8'hFF, 8'hFF, 8'hFF, 0, NO_TARGET);
      for (i = 0; i < 4; i++) add_pix(8'hA5, 8'h5A, 8'hFF, 0, NO_TARGET);
      add_pix(8'hFF, 8'hFF, 8'hFF, 0, NO_TARGET);
      // Row length not a multiple of three, target at the right edge.
      add_reg(REG_ROW_BYTES, 13'd10);
      add_reg(REG_FRAME_HEIGHT, 13'd1);
      for (i = 0; i < 3; i++) add_pix(8'h00, 8'hFF, 8'hFF, 0, NO_TARGET);
      add_pix(8'hFF, 8'hFF, 8'hFF, 0, NO_TARGET);
      // Zero row length and height: every pixel is a frame and no divisor is usable.
      add_reg(REG_ROW_BYTES, 13'd0);
      add_reg(REG_FRAME_HEIGHT, 13'd0);
      add_pix(8'hFF, 8'hFF, 8'hFF, 1, steer_t'{1'b1, DRIVE_ZERO, DRIVE_ZERO, 13'd0, 11'd0});
      add_pix(8'h00, 8'h00, 8'h00, 1, NO_TARGET);

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].is_reg) begin
            if (!reg_busy) wait_idle();
            write_reg(plan[i].idx, plan[i].value);
            reg_busy = 1;
         end else begin
            if (reg_busy) begin
               csr_bus.valid <= 1'b0;
               reg_busy = 0;
            end
            send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
         end
      end

      loop_pixels = pixels_sent;
      while (pixels_sent - loop_pixels < RANDOM_PIXELS) begin
         run_phase($urandom_range(0, 3) != 0, pick_row_bytes(),
                   $urandom_range(0, 3) != 0, pick_height(),
                   $urandom_range(5, 160), pick_density());
      end

      wait_idle();
      $display("Sent %0d pixels and %0d register writes; checked %0d frame results.",
               pixels_sent, reg_writes, results_checked);
      $display("Of those, %0d had a target: %0d turning and %0d driving forward.",
               found_count, turn_count, forward_count);
      if (mismatches == 0 && pending_steer.size() == 0) begin
         $display("white_blob_steering_tracker: match");
      end else begin
         $display("white_blob_steering_tracker: mismatch");
      end
      $finish;
   end

endmodule
